// ===== hdl/taiir_pkg.sv =====
package taiir_pkg;

    localparam int HistDepth = 4;
    localparam int CoefWidth = 32;
    localparam int ErrWidth = 33;
    localparam int DriveWidth = 48;
    localparam int AccWidth = 84;
    localparam int FracShift = 28;
    localparam int ErrScale = 16;
    localparam int CfgIndexWidth = 3;

    typedef logic signed [CoefWidth-1:0] coef_t;
    typedef logic signed [ErrWidth-1:0] err_t;
    typedef logic signed [DriveWidth-1:0] drive_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_COEF_DRIVE_OLDEST = 3'd0,
        REG_COEF_DRIVE_THIRD  = 3'd1,
        REG_COEF_DRIVE_SECOND = 3'd2,
        REG_COEF_ERROR_OLDEST = 3'd3,
        REG_COEF_ERROR_THIRD  = 3'd4,
        REG_COEF_ERROR_SECOND = 3'd5,
        REG_COEF_ERROR_NEWEST = 3'd6
    } cfg_index_t;

    typedef struct packed {
        coef_t drive_oldest;
        coef_t drive_third;
        coef_t drive_second;
        coef_t error_oldest;
        coef_t error_third;
        coef_t error_second;
        coef_t error_newest;
    } coef_set_t;

    localparam coef_t RstDriveOldest = 32'sd355543650;
    localparam coef_t RstDriveThird  = -32'sd973834057;
    localparam coef_t RstDriveSecond = 32'sd886725863;
    localparam coef_t RstErrorOldest = -32'sd3300156;
    localparam coef_t RstErrorThird  = 32'sd2176994;
    localparam coef_t RstErrorSecond = 32'sd3232959;
    localparam coef_t RstErrorNewest = -32'sd2243836;

endpackage

// ===== hdl/two_axis_iir_speed_controller_core.sv =====
// Two-axis IIR speed controller. Each input word carries a target and a
// measured value per axis; each output word carries the new floored and
// saturated drive per axis. The block takes one word per clock cycle while
// the output does not stall: the word is held in an input register, the
// seven-term multiply-accumulate and history update of both axes are
// computed combinationally from it, and the drives land in the result
// register. The result register lets a new word enter while a finished
// result waits downstream. Coefficient writes are accepted in any cycle and
// take effect on the next word computed.
module two_axis_iir_speed_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  target_x,
    input  logic signed [31:0]                  target_y,
    input  logic signed [31:0]                  measured_x,
    input  logic signed [31:0]                  measured_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  drive_x,
    output logic signed [31:0]                  drive_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [taiir_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [taiir_pkg::CoefWidth-1:0]     cfg_data
);

    taiir_pkg::coef_set_t coefs;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic signed [31:0]  target_x_reg;
    logic signed [31:0]  target_y_reg;
    logic signed [31:0]  measured_x_reg;
    logic signed [31:0]  measured_y_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic signed [31:0]  drive_x_reg;
    logic signed [31:0]  drive_y_reg;
    logic signed [31:0]  drive_x_next;
    logic signed [31:0]  drive_y_next;
    logic                in_accept;
    logic                advance;

    assign cfg_ready = 1'b1;

    taiir_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coefs    (coefs)
    );

    taiir_axis u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .target   (target_x_reg),
        .measured (measured_x_reg),
        .coefs    (coefs),
        .drive    (drive_x_next)
    );

    taiir_axis u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .target   (target_y_reg),
        .measured (measured_y_reg),
        .coefs    (coefs),
        .drive    (drive_y_next)
    );

    always_comb
    begin
        advance = in_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = in_valid_reg && !advance;
        in_accept = in_valid && !in_stall;

        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            target_x_reg   <= target_x;
            target_y_reg   <= target_y;
            measured_x_reg <= measured_x;
            measured_y_reg <= measured_y;
        end
        if (advance)
        begin
            drive_x_reg <= drive_x_next;
            drive_y_reg <= drive_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_x = drive_x_reg;
    assign drive_y = drive_y_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_valid_reg)
        else $error("accepted word not held in the input register");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed result not presented");

    a_result_only_leaves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && !advance |=> out_valid_reg && $stable(drive_x_reg))
        else $error("stalled result lost");

endmodule

// ===== hdl/taiir_cfg.sv =====
module taiir_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [taiir_pkg::CfgIndexWidth-1:0]    wr_index,
    input  logic [taiir_pkg::CoefWidth-1:0]        wr_data,
    output taiir_pkg::coef_set_t                   coefs
);

    taiir_pkg::coef_set_t coefs_reg;
    taiir_pkg::coef_set_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (wr_en)
        begin
            case (wr_index)
                taiir_pkg::REG_COEF_DRIVE_OLDEST: coefs_next.drive_oldest = wr_data;
                taiir_pkg::REG_COEF_DRIVE_THIRD:  coefs_next.drive_third  = wr_data;
                taiir_pkg::REG_COEF_DRIVE_SECOND: coefs_next.drive_second = wr_data;
                taiir_pkg::REG_COEF_ERROR_OLDEST: coefs_next.error_oldest = wr_data;
                taiir_pkg::REG_COEF_ERROR_THIRD:  coefs_next.error_third  = wr_data;
                taiir_pkg::REG_COEF_ERROR_SECOND: coefs_next.error_second = wr_data;
                taiir_pkg::REG_COEF_ERROR_NEWEST: coefs_next.error_newest = wr_data;
                default:                          coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.drive_oldest <= taiir_pkg::RstDriveOldest;
            coefs_reg.drive_third  <= taiir_pkg::RstDriveThird;
            coefs_reg.drive_second <= taiir_pkg::RstDriveSecond;
            coefs_reg.error_oldest <= taiir_pkg::RstErrorOldest;
            coefs_reg.error_third  <= taiir_pkg::RstErrorThird;
            coefs_reg.error_second <= taiir_pkg::RstErrorSecond;
            coefs_reg.error_newest <= taiir_pkg::RstErrorNewest;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// ===== hdl/taiir_axis.sv =====
module taiir_axis (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic signed [31:0]            target,
    input  logic signed [31:0]            measured,
    input  taiir_pkg::coef_set_t          coefs,
    output logic signed [31:0]            drive
);

    localparam int AccW = taiir_pkg::AccWidth;
    localparam int QW = AccW - taiir_pkg::FracShift;
    localparam int DW = taiir_pkg::DriveWidth;
    localparam int HiW = DW - taiir_pkg::ErrScale;

    taiir_pkg::err_t   eh_reg   [taiir_pkg::HistDepth];
    taiir_pkg::err_t   eh_next  [taiir_pkg::HistDepth];
    taiir_pkg::drive_t dh_reg   [taiir_pkg::HistDepth];
    taiir_pkg::drive_t dh_next  [taiir_pkg::HistDepth];

    taiir_pkg::err_t        err_new;
    logic signed [AccW-1:0] acc;
    logic signed [QW-1:0]   q;
    taiir_pkg::drive_t      d_new;

    function automatic logic signed [AccW-1:0] drive_term(
        input logic signed [31:0]  c,
        input taiir_pkg::drive_t   d
    );
        logic signed [HiW-1:0]  d_hi;
        logic signed [16:0]     d_lo;
        logic signed [63:0]     p_hi;
        logic signed [48:0]     p_lo;
        d_hi = d[DW-1:taiir_pkg::ErrScale];
        d_lo = $signed({1'b0, d[taiir_pkg::ErrScale-1:0]});
        p_hi = c * d_hi;
        p_lo = c * d_lo;
        return (AccW'(p_hi) <<< taiir_pkg::ErrScale) + AccW'(p_lo);
    endfunction

    function automatic logic signed [AccW-1:0] error_term(
        input logic signed [31:0] c,
        input taiir_pkg::err_t    e
    );
        logic signed [64:0] p;
        p = c * e;
        return AccW'(p) <<< taiir_pkg::ErrScale;
    endfunction

    always_comb
    begin
        err_new = taiir_pkg::ErrWidth'(target) - taiir_pkg::ErrWidth'(measured);
        acc = drive_term($signed(coefs.drive_oldest), dh_reg[3])
            + drive_term($signed(coefs.drive_third), dh_reg[2])
            + drive_term($signed(coefs.drive_second), dh_reg[1])
            + error_term($signed(coefs.error_oldest), eh_reg[2])
            + error_term($signed(coefs.error_third), eh_reg[1])
            + error_term($signed(coefs.error_second), eh_reg[0])
            + error_term($signed(coefs.error_newest), err_new);
        q = acc[AccW-1:taiir_pkg::FracShift];
        if (q[QW-1:DW-1] == '0 || q[QW-1:DW-1] == '1)
        begin
            d_new = q[DW-1:0];
        end
        else if (q[QW-1])
        begin
            d_new = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            d_new = {1'b0, {(DW-1){1'b1}}};
        end
        drive = d_new[DW-1:taiir_pkg::ErrScale];

        eh_next = eh_reg;
        dh_next = dh_reg;
        if (advance)
        begin
            eh_next[0] = err_new;
            dh_next[0] = d_new;
            for (int i = 1; i < taiir_pkg::HistDepth; i++)
            begin
                eh_next[i] = eh_reg[i-1];
                dh_next[i] = dh_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < taiir_pkg::HistDepth; i++)
            begin
                eh_reg[i] <= '0;
                dh_reg[i] <= '0;
            end
        end
        else
        begin
            eh_reg <= eh_next;
            dh_reg <= dh_next;
        end
    end

endmodule
